// File: design/palette_table_with_reverse_search_unit_defines.svh
// ----------------------------------------------------------------------------
// palette table assertion macros
// concurrent assertion wrappers used by the palette table top level
// ----------------------------------------------------------------------------
`ifndef PALETTE_TABLE_WITH_REVERSE_SEARCH_UNIT_DEFINES_SVH
`define PALETTE_TABLE_WITH_REVERSE_SEARCH_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// expression holds at every clock edge out of reset
`define PTRS_ASSERT_NOW(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("palette table assertion failed");

// antecedent implies consequent in the same cycle
`define PTRS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("palette table assertion failed");

// antecedent implies consequent in the next cycle
`define PTRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("palette table assertion failed");

`else

`define PTRS_ASSERT_NOW(label, clk, rst_n, expr)
`define PTRS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PTRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/ptrs_pkg.sv
// ----------------------------------------------------------------------------
// palette table package
// field widths, command codes, controller states and control structs
// ----------------------------------------------------------------------------
package ptrs_pkg;

    // fixed field widths of the transaction payloads
    localparam int CMD_W       = 3;
    localparam int POS_W       = 8;
    localparam int CNT_FIELD_W = 9;
    localparam int COMP_W      = 16;
    localparam int IDX_OUT_W   = 8;

    // parameter defaults
    localparam int PTRS_DEPTH_DEFAULT     = 256;
    localparam int PTRS_COMP_BITS_DEFAULT = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT = 3'd0,
        CMD_SET  = 3'd1,
        CMD_ADD  = 3'd2,
        CMD_GET  = 3'd3,
        CMD_FIND = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CLEAR,
        S_READ,
        S_SCAN,
        S_RESULT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_item;   // latch the accepted transaction, clear the result
        logic set_error;   // flag an error in the result
        logic set_count;   // pen count takes the init count
        logic wr_pos;      // write the pen at the given position
        logic wr_add;      // append the pen at the count
        logic clr_step;    // write black at the clear pointer and step it
        logic rd_pos;      // read the entry at the given position
        logic rd_first;    // read entry zero to start a search
        logic rd_next;     // read the entry after the one last read
        logic take_colour; // copy the read pen into the result
        logic take_match;  // report the last read entry as found
        logic load_out;    // move the result into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_cmd command;
        logic init_bad;
        logic new_zero;
        logic pos_bad;
        logic full;
        logic count_zero;
        logic clr_last;
        logic scan_match;
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

// File: design/ptrs_item_if.sv
// ----------------------------------------------------------------------------
// palette table command channel
// valid/ready channel carrying one palette command
// ----------------------------------------------------------------------------
interface ptrs_item_if
    import ptrs_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       command;
    logic [POS_W-1:0]       position;
    logic [CNT_FIELD_W-1:0] new_count;
    logic [COMP_W-1:0]      red;
    logic [COMP_W-1:0]      green;
    logic [COMP_W-1:0]      blue;

    modport source (
        output valid, command, position, new_count, red, green, blue,
        input  ready
    );

    modport sink (
        input  valid, command, position, new_count, red, green, blue,
        output ready
    );
endinterface

// File: design/ptrs_result_if.sv
// ----------------------------------------------------------------------------
// palette table result channel
// valid/ready channel carrying one command result
// ----------------------------------------------------------------------------
interface ptrs_result_if
    import ptrs_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 status;
    logic                 found;
    logic [IDX_OUT_W-1:0] index_out;
    logic [COMP_W-1:0]    red_out;
    logic [COMP_W-1:0]    green_out;
    logic [COMP_W-1:0]    blue_out;

    modport source (
        output valid, status, found, index_out, red_out, green_out, blue_out,
        input  ready
    );

    modport sink (
        input  valid, status, found, index_out, red_out, green_out, blue_out,
        output ready
    );
endinterface

// File: design/ptrs_ctrl.sv
// ----------------------------------------------------------------------------
// palette table controller
// sequences one command at a time: execute, clear walk, read, search walk
// ----------------------------------------------------------------------------
module ptrs_ctrl
    import ptrs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESULT;
                case (i_stat.command)
                    CMD_INIT: begin
                        if (i_stat.init_bad) begin
                            o_cmd.set_error = 1'b1;
                        end else begin
                            o_cmd.set_count = 1'b1;
                            if (!i_stat.new_zero) begin
                                n_state = S_CLEAR;
                            end
                        end
                    end
                    CMD_SET: begin
                        if (i_stat.pos_bad) begin
                            o_cmd.set_error = 1'b1;
                        end else begin
                            o_cmd.wr_pos = 1'b1;
                        end
                    end
                    CMD_ADD: begin
                        if (i_stat.full) begin
                            o_cmd.set_error = 1'b1;
                        end else begin
                            o_cmd.wr_add = 1'b1;
                        end
                    end
                    CMD_GET: begin
                        if (i_stat.pos_bad) begin
                            o_cmd.set_error = 1'b1;
                        end else begin
                            o_cmd.rd_pos = 1'b1;
                            n_state      = S_READ;
                        end
                    end
                    CMD_FIND: begin
                        if (!i_stat.count_zero) begin
                            o_cmd.rd_first = 1'b1;
                            n_state        = S_SCAN;
                        end
                    end
                    default: begin
                        o_cmd.set_error = 1'b1;
                    end
                endcase
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_RESULT;
                end
            end
            S_READ: begin
                o_cmd.take_colour = 1'b1;
                n_state           = S_RESULT;
            end
            S_SCAN: begin
                if (i_stat.scan_match) begin
                    o_cmd.take_match = 1'b1;
                    n_state          = S_RESULT;
                end else if (i_stat.scan_last) begin
                    n_state = S_RESULT;
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/ptrs_datapath.sv
// ----------------------------------------------------------------------------
// palette table datapath
// pen memory, pen count, command latch, comparators and output register
// ----------------------------------------------------------------------------
module ptrs_datapath
    import ptrs_pkg::*;
#(
    parameter int PALETTE_DEPTH  = PTRS_DEPTH_DEFAULT,
    parameter int COMPONENT_BITS = PTRS_COMP_BITS_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    input  logic [CMD_W-1:0]       i_command,
    input  logic [POS_W-1:0]       i_position,
    input  logic [CNT_FIELD_W-1:0] i_new_count,
    input  logic [COMP_W-1:0]      i_red,
    input  logic [COMP_W-1:0]      i_green,
    input  logic [COMP_W-1:0]      i_blue,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_status,
    output logic                   o_found,
    output logic [IDX_OUT_W-1:0]   o_index_out,
    output logic [COMP_W-1:0]      o_red_out,
    output logic [COMP_W-1:0]      o_green_out,
    output logic [COMP_W-1:0]      o_blue_out
);

    localparam int IDX_W      = $clog2(PALETTE_DEPTH);
    localparam int CNT_W      = $clog2(PALETTE_DEPTH + 1);
    localparam int STORE_BITS = (COMPONENT_BITS < COMP_W) ? COMPONENT_BITS : COMP_W;
    localparam int PEN_W      = 3 * STORE_BITS;

    // latched transaction
    t_cmd                   r_command;
    logic [POS_W-1:0]       r_position;
    logic [CNT_FIELD_W-1:0] r_new_count;
    logic [PEN_W-1:0]       r_pen;

    // table state
    logic [PEN_W-1:0]       r_mem [PALETTE_DEPTH];
    logic [CNT_W-1:0]       r_count;
    logic [IDX_W-1:0]       r_clr_ptr;
    logic [IDX_W-1:0]       r_rd_idx;
    logic [PEN_W-1:0]       r_rd_data;

    // result being built
    logic                   r_status;
    logic                   r_found;
    logic [IDX_W-1:0]       r_idx;
    logic [PEN_W-1:0]       r_colour;

    // output register
    logic                   r_out_valid;
    logic                   r_out_status;
    logic                   r_out_found;
    logic [IDX_OUT_W-1:0]   r_out_index;
    logic [PEN_W-1:0]       r_out_colour;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [PEN_W-1:0]       wr_data;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;

    // memory port selection
    always_comb begin
        wr_en   = i_cmd.wr_pos | i_cmd.wr_add | i_cmd.clr_step;
        wr_addr = r_clr_ptr;
        wr_data = '0;
        if (i_cmd.wr_pos) begin
            wr_addr = r_position[IDX_W-1:0];
            wr_data = r_pen;
        end else if (i_cmd.wr_add) begin
            wr_addr = r_count[IDX_W-1:0];
            wr_data = r_pen;
        end
        rd_en   = i_cmd.rd_pos | i_cmd.rd_first | i_cmd.rd_next;
        rd_addr = r_rd_idx + IDX_W'(1);
        if (i_cmd.rd_pos) begin
            rd_addr = r_position[IDX_W-1:0];
        end else if (i_cmd.rd_first) begin
            rd_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_idx  <= rd_addr;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.set_count) begin
                r_count <= CNT_W'(r_new_count);
            end else if (i_cmd.wr_add) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_command   <= t_cmd'(i_command);
            r_position  <= i_position;
            r_new_count <= i_new_count;
            r_pen       <= {i_red[STORE_BITS-1:0], i_green[STORE_BITS-1:0],
                            i_blue[STORE_BITS-1:0]};
            r_clr_ptr   <= '0;
            r_status    <= 1'b0;
            r_found     <= 1'b0;
            r_idx       <= '0;
            r_colour    <= '0;
        end
        if (i_cmd.clr_step) begin
            r_clr_ptr <= r_clr_ptr + IDX_W'(1);
        end
        if (i_cmd.set_error) begin
            r_status <= 1'b1;
        end
        if (i_cmd.wr_add) begin
            r_found <= 1'b1;
            r_idx   <= r_count[IDX_W-1:0];
        end
        if (i_cmd.take_match) begin
            r_found <= 1'b1;
            r_idx   <= r_rd_idx;
        end
        if (i_cmd.take_colour) begin
            r_colour <= r_rd_data;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_found  <= r_found;
            r_out_index  <= IDX_OUT_W'(r_idx);
            r_out_colour <= r_colour;
        end
    end

    // status to the controller
    always_comb begin
        o_stat.command    = r_command;
        o_stat.init_bad   = r_new_count > CNT_FIELD_W'(PALETTE_DEPTH);
        o_stat.new_zero   = r_new_count == '0;
        o_stat.pos_bad    = CNT_FIELD_W'(r_position) >= CNT_FIELD_W'(r_count);
        o_stat.full       = r_count >= CNT_W'(PALETTE_DEPTH);
        o_stat.count_zero = r_count == '0;
        o_stat.clr_last   = (CNT_FIELD_W'(r_clr_ptr) + CNT_FIELD_W'(1)) == r_new_count;
        o_stat.scan_match = r_rd_data == r_pen;
        o_stat.scan_last  = (CNT_W'(r_rd_idx) + CNT_W'(1)) == r_count;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_found     = r_out_found;
    assign o_index_out = r_out_index;
    assign o_red_out   = COMP_W'(r_out_colour[3*STORE_BITS-1 -: STORE_BITS]);
    assign o_green_out = COMP_W'(r_out_colour[2*STORE_BITS-1 -: STORE_BITS]);
    assign o_blue_out  = COMP_W'(r_out_colour[STORE_BITS-1:0]);

endmodule

// File: design/palette_table_with_reverse_search_unit.sv
// ----------------------------------------------------------------------------
// palette table with reverse search
// A colour palette of up to PALETTE_DEPTH RGB pens with a pen count, driven
// one command per transaction: init (set the count and clear that many pens
// to black), set, add (append and report the index), get and find (lowest
// index below the count whose pen equals the given colour). Components are
// masked to COMPONENT_BITS. A bad position, an add to a full table, an init
// count above the depth or an unknown command give status 1 and change
// nothing. Commands run one at a time through a single-port pen memory with
// registered read data. Set, add and error results pass the execute and result
// states before valid rises, get also a read state, init a clear walk and
// find a search walk, the walks stepping one entry per cycle through the
// memory port. The controller is back in idle in the cycle the result valid
// rises. The result waits in an output register, so the next command is
// taken while it waits.
// There is no clearing pass after reset: pens are only ever read below the
// count, and every such pen has been written by init or add.
// ----------------------------------------------------------------------------
`include "palette_table_with_reverse_search_unit_defines.svh"

module palette_table_with_reverse_search_unit
    import ptrs_pkg::*;
#(
    parameter int PALETTE_DEPTH  = PTRS_DEPTH_DEFAULT,
    parameter int COMPONENT_BITS = PTRS_COMP_BITS_DEFAULT
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ptrs_item_if.sink     i_item,
    ptrs_result_if.source o_result
);

    // command and status between controller and datapath
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    assign i_item.ready = w_in_ready;

    // sequencer: one command in flight, walks for init and find
    ptrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // pen memory, count, comparators and the result register
    ptrs_datapath #(
        .PALETTE_DEPTH  (PALETTE_DEPTH),
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_command   (i_item.command),
        .i_position  (i_item.position),
        .i_new_count (i_item.new_count),
        .i_red       (i_item.red),
        .i_green     (i_item.green),
        .i_blue      (i_item.blue),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .o_status    (o_result.status),
        .o_found     (o_result.found),
        .o_index_out (o_result.index_out),
        .o_red_out   (o_result.red_out),
        .o_green_out (o_result.green_out),
        .o_blue_out  (o_result.blue_out)
    );

    // a transaction taken in leaves the controller busy for the next cycle
    `PTRS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_item.valid && i_item.ready, !i_item.ready)

    // a result is never loaded while the controller is taking a command
    `PTRS_ASSERT_NOW(a_no_load_when_idle, i_clk, i_rst_n, !(w_cmd.load_out && i_item.ready))

    // output valid only rises after the controller loaded a result
    `PTRS_ASSERT_SAME(a_valid_from_load, i_clk, i_rst_n, $rose(o_result.valid), $past(w_cmd.load_out))

    // an error result never reports a hit
    `PTRS_ASSERT_SAME(a_error_not_found, i_clk, i_rst_n, o_result.valid, !(o_result.status && o_result.found))

endmodule
